// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Depth, widths, record and control types, status and action codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;
    localparam int KEY_W   = 16;
    localparam int PLACE_W = 8;
    localparam int KIND_W  = 8;
    localparam int EXP_W   = 16;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PLACE_W-1:0] pickup;
        logic [PLACE_W-1:0] dropoff;
        logic [KIND_W-1:0]  kind;
        logic [EXP_W-1:0]   expiry;
    } t_rec;

    typedef struct packed {
        logic enq;
        logic deq;
        t_rec rec;
    } t_cell_ctl;

endpackage

// File: rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one enqueue or dequeue request word.
// ----------------------------------------------------------------------------
interface spq_req_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [KEY_W-1:0]   key_time;
    logic [PLACE_W-1:0] pickup_place;
    logic [PLACE_W-1:0] dropoff_place;
    logic [KIND_W-1:0]  item_kind;
    logic [EXP_W-1:0]   expiry_left;

    modport source (
        output valid, action, key_time, pickup_place, dropoff_place, item_kind,
               expiry_left,
        input  ready
    );

    modport sink (
        input  valid, action, key_time, pickup_place, dropoff_place, item_kind,
               expiry_left,
        output ready
    );
endinterface

// File: rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface spq_rsp_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               out_valid;
    logic [KEY_W-1:0]   out_key_time;
    logic [PLACE_W-1:0] out_pickup;
    logic [PLACE_W-1:0] out_dropoff;
    logic [KIND_W-1:0]  out_item_kind;
    logic [EXP_W-1:0]   out_expiry;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;

    modport source (
        output valid, status, out_valid, out_key_time, out_pickup, out_dropoff,
               out_item_kind, out_expiry, count, is_empty, is_full,
        input  ready
    );

    modport sink (
        input  valid, status, out_valid, out_key_time, out_pickup, out_dropoff,
               out_item_kind, out_expiry, count, is_empty, is_full,
        output ready
    );
endinterface

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one record; compares the incoming key and takes the new record,
// its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  logic      i_left_ins,
    input  t_rec      i_left_rec,
    input  t_rec      i_right_rec,
    output logic      o_ins,
    output t_rec      o_rec
);

    t_rec r_rec;
    t_rec n_rec;

    assign o_ins = !i_occupied || (i_ctl.rec.key < r_rec.key);
    assign o_rec = r_rec;

    always_comb begin
        priority if (i_ctl.enq && o_ins) begin
            n_rec = i_left_ins ? i_left_rec : i_ctl.rec;
        end else if (i_ctl.deq) begin
            n_rec = i_right_rec;
        end else begin
            n_rec = r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Row of compare-and-shift cells kept in ascending key order; equal keys
// leave in arrival order. Full enqueues and empty dequeues are flagged.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | word
//  i_req   | in  | valid/ready  | action, key, pickup, dropoff, kind, expiry
//  o_rsp   | out | valid/ready  | status, dequeued record, count, flags
//
//  One request per cycle; its response is registered and shows the cycle
//  after acceptance. The cell row is updated on the accepting edge.
//  Reset clears the count and the response valid; cells
//  are not cleared and no clearing pass runs.
//  i_req.ready drops only while a response waits on a stalled o_rsp.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_rsp_valid;
    t_status          r_status;
    logic             r_out_valid;
    t_rec             r_out_rec;
    logic [CNT_W-1:0] r_rsp_count;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_do_enq;
    logic      w_do_deq;
    t_status   w_status;
    t_cell_ctl w_ctl;
    t_rec      w_new_rec;

    logic [DEPTH-1:0] w_ins;
    logic [DEPTH-1:0] w_occ;
    t_rec             w_rec [DEPTH];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_do_enq    = w_accept && (i_req.action == ACT_ENQ) && !w_full;
    assign w_do_deq    = w_accept && (i_req.action == ACT_DEQ) && !w_empty;

    assign w_new_rec.key     = i_req.key_time;
    assign w_new_rec.pickup  = i_req.pickup_place;
    assign w_new_rec.dropoff = i_req.dropoff_place;
    assign w_new_rec.kind    = i_req.item_kind;
    assign w_new_rec.expiry  = i_req.expiry_left;

    assign w_ctl.enq = w_do_enq;
    assign w_ctl.deq = w_do_deq;
    assign w_ctl.rec = w_new_rec;

    always_comb begin
        priority if (w_do_enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_deq) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        priority if (i_req.action == ACT_ENQ && w_full) begin
            w_status = ST_FULL;
        end else if (i_req.action == ACT_DEQ && w_empty) begin
            w_status = ST_EMPTY;
        end else begin
            w_status = ST_OK;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occupied  (w_occ[g]),
                .i_left_ins  (1'b0),
                .i_left_rec  (w_new_rec),
                .i_right_rec (w_rec[g+1]),
                .o_ins       (w_ins[g]),
                .o_rec       (w_rec[g])
            );
        end else if (g == DEPTH - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occupied  (w_occ[g]),
                .i_left_ins  (w_ins[g-1]),
                .i_left_rec  (w_rec[g-1]),
                .i_right_rec (w_rec[g]),
                .o_ins       (w_ins[g]),
                .o_rec       (w_rec[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occupied  (w_occ[g]),
                .i_left_ins  (w_ins[g-1]),
                .i_left_rec  (w_rec[g-1]),
                .i_right_rec (w_rec[g+1]),
                .o_ins       (w_ins[g]),
                .o_rec       (w_rec[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_out_valid <= w_do_deq;
            r_out_rec   <= w_do_deq ? w_rec[0] : '0;
            r_rsp_count <= n_count;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.out_valid     = r_out_valid;
    assign o_rsp.out_key_time  = r_out_rec.key;
    assign o_rsp.out_pickup    = r_out_rec.pickup;
    assign o_rsp.out_dropoff   = r_out_rec.dropoff;
    assign o_rsp.out_item_kind = r_out_rec.kind;
    assign o_rsp.out_expiry    = r_out_rec.expiry;
    assign o_rsp.count         = COUNT_W'(r_rsp_count);
    assign o_rsp.is_empty      = (r_rsp_count == '0);
    assign o_rsp.is_full       = (r_rsp_count == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_rec[0].key <= w_rec[1].key))
        else $error("head cells out of order");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_do_deq) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dequeue did not lower count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && i_req.action == ACT_ENQ && w_full)
        |=> (r_count == CNT_W'(DEPTH)))
        else $error("refused enqueue changed count");

endmodule
